/* sv/hgcm_pkg.sv */
// Shared constants and types for the height gradient colour map.
package hgcm_pkg;

    // Default field widths
    localparam int HEIGHT_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    // Ratio input: unsigned Q0.16 with one extra bit so that 1.0 fits
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_BITS = RATIO_FRAC + 1;
    localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1) << RATIO_FRAC;

    // Colour format
    localparam int CHAN_BITS = 8;
    localparam int NUM_CHAN  = 3;
    localparam int RGB_BITS  = CHAN_BITS * NUM_CHAN;
    localparam int SEG_BITS  = 2;

    // APB-style register port
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 5;

    // Register map, word index
    typedef enum logic [2:0] {
        REG_HEIGHT_MIN   = 3'd0,
        REG_HEIGHT_MAX   = 3'd1,
        REG_STOP_COLOR_0 = 3'd2,
        REG_STOP_COLOR_1 = 3'd3,
        REG_STOP_COLOR_2 = 3'd4,
        REG_STOP_COLOR_3 = 3'd5,
        REG_STOP_COLOR_4 = 3'd6
    } cfg_reg_t;

    // Palette segment codes
    typedef enum logic [SEG_BITS-1:0] {
        SEG_0 = 2'd0,
        SEG_1 = 2'd1,
        SEG_2 = 2'd2,
        SEG_3 = 2'd3
    } seg_t;

    // Reset values
    localparam logic [RGB_BITS-1:0] STOP_COLOR_0_RST = 24'h0000FF;
    localparam logic [RGB_BITS-1:0] STOP_COLOR_1_RST = 24'h00FFFF;
    localparam logic [RGB_BITS-1:0] STOP_COLOR_2_RST = 24'h00FF00;
    localparam logic [RGB_BITS-1:0] STOP_COLOR_3_RST = 24'hFFFF00;
    localparam logic [RGB_BITS-1:0] STOP_COLOR_4_RST = 24'hFF0000;
    localparam int HEIGHT_MIN_RST = 0;
    localparam int HEIGHT_MAX_RST = 100;

endpackage

/* sv/hgcm_scale.sv */
// Height normalisation: range check stage followed by a one-bit-per-stage divider.
module hgcm_scale
    import hgcm_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [HEIGHT_BITS-1:0] height,
    input  logic signed [HEIGHT_BITS-1:0] height_min,
    input  logic signed [HEIGHT_BITS-1:0] height_max,
    output logic        [FRAC_BITS:0]     scale
);

    localparam logic [FRAC_BITS:0] SCALE_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Stage 0 holds the prepared operands, stages 1..FRAC_BITS one quotient bit each
    logic [HEIGHT_BITS-1:0] rem_reg  [FRAC_BITS+1];
    logic [HEIGHT_BITS-1:0] den_reg  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0]   quo_reg  [FRAC_BITS+1];
    logic                   full_reg [FRAC_BITS+1];

    logic signed [HEIGHT_BITS:0] num_raw;
    logic signed [HEIGHT_BITS:0] den_raw;
    logic signed [HEIGHT_BITS:0] num_abs;
    logic signed [HEIGHT_BITS:0] den_abs;
    logic                        zero_scale;
    logic                        full_scale;
    logic [HEIGHT_BITS-1:0]      rem_next;
    logic [HEIGHT_BITS-1:0]      den_next;

    // Differences against the range; a reversed range flips both signs
    always_comb
    begin
        num_raw = {height[HEIGHT_BITS-1], height} - {height_min[HEIGHT_BITS-1], height_min};
        den_raw = {height_max[HEIGHT_BITS-1], height_max}
                - {height_min[HEIGHT_BITS-1], height_min};
        if (den_raw[HEIGHT_BITS])
        begin
            num_abs = -num_raw;
            den_abs = -den_raw;
        end
        else
        begin
            num_abs = num_raw;
            den_abs = den_raw;
        end
        // Empty range or height at/below the low end gives zero; at/above the top, full
        zero_scale = (den_abs == '0) || num_abs[HEIGHT_BITS] || (num_abs == '0);
        full_scale = !zero_scale && (num_abs >= den_abs);
        // Clamped cases feed 0/1 so the divider returns a zero quotient
        if (zero_scale || full_scale)
        begin
            rem_next = '0;
            den_next = HEIGHT_BITS'(1);
        end
        else
        begin
            rem_next = num_abs[HEIGHT_BITS-1:0];
            den_next = den_abs[HEIGHT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next;
            den_reg[0]  <= den_next;
            quo_reg[0]  <= '0;
            full_reg[0] <= full_scale;
        end
    end

    // Restoring division, one quotient bit per stage
    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_div
        logic [HEIGHT_BITS:0] rem_dbl;
        logic [HEIGHT_BITS:0] rem_sub;
        logic                 q_bit;

        assign rem_dbl = {rem_reg[k-1], 1'b0};
        assign rem_sub = rem_dbl - {1'b0, den_reg[k-1]};
        assign q_bit   = (rem_dbl >= {1'b0, den_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= q_bit ? rem_sub[HEIGHT_BITS-1:0] : rem_dbl[HEIGHT_BITS-1:0];
                den_reg[k]  <= den_reg[k-1];
                quo_reg[k]  <= {quo_reg[k-1][FRAC_BITS-2:0], q_bit};
                full_reg[k] <= full_reg[k-1];
            end
        end
    end

    assign scale = full_reg[FRAC_BITS] ? SCALE_ONE : {1'b0, quo_reg[FRAC_BITS]};

endmodule

/* sv/height_gradient_color_map.sv */
// Top level: register file, height scaling, interpolation and palette blend pipeline.
//
//  channel   signals                                   direction  transfer when
//  item      item_valid/item_stall, start_height,      in         item_valid && !item_stall
//            end_height, ratio
//  pixel     pixel_valid/pixel_stall, pixel_rgb        out        pixel_valid && !pixel_stall
//  config    psel/penable/pwrite/paddr/pwdata/prdata   in/out     psel && penable && pwrite
//
//  One item per cycle while the pixel side does not stall; the division
//  produces one quotient bit per pipeline stage.
//  Reset empties the pipeline and loads the default range and palette.
//  A stall on a valid pixel freezes the whole pipeline, bubbles included,
//  and is passed straight back as item_stall.
module height_gradient_color_map
    import hgcm_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // item channel
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [HEIGHT_BITS-1:0] start_height,
    input  logic signed [HEIGHT_BITS-1:0] end_height,
    input  logic        [RATIO_BITS-1:0]  ratio,
    // pixel channel
    output logic                          pixel_valid,
    input  logic                          pixel_stall,
    output logic        [RGB_BITS-1:0]    pixel_rgb,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_BITS-1:0]      paddr,
    input  logic [APB_DATA_BITS-1:0]      pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready
);

    localparam int N_STAGES = FRAC_BITS + 6;
    localparam int ST_A     = FRAC_BITS + 1;  // interpolation products
    localparam int PROD_W   = FRAC_BITS + 1 + RATIO_BITS;
    localparam int BLEND_W  = CHAN_BITS + FRAC_BITS + 1;
    localparam logic [FRAC_BITS+2:0] Q_ONE = (FRAC_BITS+3)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0]   T_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // ---------------- register file ----------------
    logic signed [HEIGHT_BITS-1:0] height_min_reg;
    logic signed [HEIGHT_BITS-1:0] height_max_reg;
    logic [RGB_BITS-1:0] stop_color_0_reg;
    logic [RGB_BITS-1:0] stop_color_1_reg;
    logic [RGB_BITS-1:0] stop_color_2_reg;
    logic [RGB_BITS-1:0] stop_color_3_reg;
    logic [RGB_BITS-1:0] stop_color_4_reg;
    logic                cfg_we;
    cfg_reg_t            cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_min_reg   <= HEIGHT_BITS'(HEIGHT_MIN_RST);
            height_max_reg   <= HEIGHT_BITS'(HEIGHT_MAX_RST);
            stop_color_0_reg <= STOP_COLOR_0_RST;
            stop_color_1_reg <= STOP_COLOR_1_RST;
            stop_color_2_reg <= STOP_COLOR_2_RST;
            stop_color_3_reg <= STOP_COLOR_3_RST;
            stop_color_4_reg <= STOP_COLOR_4_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_HEIGHT_MIN:   height_min_reg   <= pwdata[HEIGHT_BITS-1:0];
                REG_HEIGHT_MAX:   height_max_reg   <= pwdata[HEIGHT_BITS-1:0];
                REG_STOP_COLOR_0: stop_color_0_reg <= pwdata[RGB_BITS-1:0];
                REG_STOP_COLOR_1: stop_color_1_reg <= pwdata[RGB_BITS-1:0];
                REG_STOP_COLOR_2: stop_color_2_reg <= pwdata[RGB_BITS-1:0];
                REG_STOP_COLOR_3: stop_color_3_reg <= pwdata[RGB_BITS-1:0];
                REG_STOP_COLOR_4: stop_color_4_reg <= pwdata[RGB_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Read back; heights sign-extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_HEIGHT_MIN:   prdata = APB_DATA_BITS'(height_min_reg);
            REG_HEIGHT_MAX:   prdata = APB_DATA_BITS'(height_max_reg);
            REG_STOP_COLOR_0: prdata = APB_DATA_BITS'(stop_color_0_reg);
            REG_STOP_COLOR_1: prdata = APB_DATA_BITS'(stop_color_1_reg);
            REG_STOP_COLOR_2: prdata = APB_DATA_BITS'(stop_color_2_reg);
            REG_STOP_COLOR_3: prdata = APB_DATA_BITS'(stop_color_3_reg);
            REG_STOP_COLOR_4: prdata = APB_DATA_BITS'(stop_color_4_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic [N_STAGES-1:0] valid_reg;
    logic                adv;

    assign adv         = !(valid_reg[N_STAGES-1] && pixel_stall);
    assign item_stall  = !adv;
    assign pixel_valid = valid_reg[N_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[N_STAGES-2:0], item_valid};
    end

    // ---------------- height scaling ----------------
    logic [FRAC_BITS:0] scale_start;
    logic [FRAC_BITS:0] scale_end;

    hgcm_scale #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale_start (
        .clk        (clk),
        .en         (adv),
        .height     (start_height),
        .height_min (height_min_reg),
        .height_max (height_max_reg),
        .scale      (scale_start)
    );

    hgcm_scale #(
        .HEIGHT_BITS (HEIGHT_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_scale_end (
        .clk        (clk),
        .en         (adv),
        .height     (end_height),
        .height_min (height_min_reg),
        .height_max (height_max_reg),
        .scale      (scale_end)
    );

    // Ratio travels beside the divider, saturated to one on entry
    logic [RATIO_BITS-1:0] ratio_reg [ST_A];
    logic [RATIO_BITS-1:0] ratio_next;

    assign ratio_next = (ratio > RATIO_ONE) ? RATIO_ONE : ratio;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ratio_reg[0] <= ratio_next;
            for (int k = 1; k < ST_A; k++)
                ratio_reg[k] <= ratio_reg[k-1];
        end
    end

    // ---------------- stage A: interpolation products ----------------
    logic [PROD_W-1:0]     prod_start_reg;
    logic [PROD_W-1:0]     prod_end_reg;
    logic [RATIO_BITS-1:0] ratio_inv;

    assign ratio_inv = RATIO_ONE - ratio_reg[ST_A-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_start_reg <= PROD_W'(scale_start) * PROD_W'(ratio_inv);
            prod_end_reg   <= PROD_W'(scale_end) * PROD_W'(ratio_reg[ST_A-1]);
        end
    end

    // ---------------- stage B: line scale ----------------
    logic [PROD_W:0]    line_sum;
    logic [FRAC_BITS:0] line_scale_reg;

    assign line_sum = {1'b0, prod_start_reg} + {1'b0, prod_end_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
            line_scale_reg <= line_sum[RATIO_FRAC +: FRAC_BITS+1];
    end

    // ---------------- stage C: segment, weight and stop colours ----------------
    logic [FRAC_BITS+2:0] quad;
    seg_t                 seg_next;
    logic [FRAC_BITS+2:0] t_wide;
    logic [RGB_BITS-1:0]  color_a_next;
    logic [RGB_BITS-1:0]  color_b_next;
    logic [FRAC_BITS:0]   t_reg;
    logic [RGB_BITS-1:0]  color_a_reg;
    logic [RGB_BITS-1:0]  color_b_reg;

    // A boundary belongs to the lower segment
    always_comb
    begin
        quad = {line_scale_reg, 2'b00};
        if (quad <= Q_ONE)
            seg_next = SEG_0;
        else if (quad <= (Q_ONE << 1))
            seg_next = SEG_1;
        else if (quad <= (Q_ONE + (Q_ONE << 1)))
            seg_next = SEG_2;
        else
            seg_next = SEG_3;

        case (seg_next)
            SEG_0:
            begin
                t_wide       = quad;
                color_a_next = stop_color_0_reg;
                color_b_next = stop_color_1_reg;
            end
            SEG_1:
            begin
                t_wide       = quad - Q_ONE;
                color_a_next = stop_color_1_reg;
                color_b_next = stop_color_2_reg;
            end
            SEG_2:
            begin
                t_wide       = quad - (Q_ONE << 1);
                color_a_next = stop_color_2_reg;
                color_b_next = stop_color_3_reg;
            end
            default:
            begin
                t_wide       = quad - (Q_ONE + (Q_ONE << 1));
                color_a_next = stop_color_3_reg;
                color_b_next = stop_color_4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg       <= t_wide[FRAC_BITS:0];
            color_a_reg <= color_a_next;
            color_b_reg <= color_b_next;
        end
    end

    // ---------------- stage D: blend products per channel ----------------
    logic [BLEND_W-1:0] blend_a_reg [NUM_CHAN];
    logic [BLEND_W-1:0] blend_b_reg [NUM_CHAN];
    logic [FRAC_BITS:0] t_inv;

    assign t_inv = T_ONE - t_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                blend_a_reg[ch] <= BLEND_W'(color_a_reg[ch*CHAN_BITS +: CHAN_BITS])
                                 * BLEND_W'(t_inv);
                blend_b_reg[ch] <= BLEND_W'(color_b_reg[ch*CHAN_BITS +: CHAN_BITS])
                                 * BLEND_W'(t_reg);
            end
        end
    end

    // ---------------- stage E: output register ----------------
    logic [BLEND_W:0]      blend_sum [NUM_CHAN];
    logic [RGB_BITS-1:0]   pixel_rgb_reg;

    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
            blend_sum[ch] = {1'b0, blend_a_reg[ch]} + {1'b0, blend_b_reg[ch]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
                pixel_rgb_reg[ch*CHAN_BITS +: CHAN_BITS] <= blend_sum[ch][FRAC_BITS +: CHAN_BITS];
        end
    end

    assign pixel_rgb = pixel_rgb_reg;

endmodule

/* sv/hgcm_checker.sv */
// Port-level checks for the height gradient colour map, bound to the top level.
module hgcm_checker
    import hgcm_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_stall,
    input logic                     pixel_valid,
    input logic                     pixel_stall,
    input logic [RGB_BITS-1:0]      pixel_rgb,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [APB_ADDR_BITS-1:0] paddr,
    input logic [APB_DATA_BITS-1:0] pwdata,
    input logic [APB_DATA_BITS-1:0] prdata
);

    // A stalled pixel transfer holds
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_rgb))
        else $error("pixel dropped or changed while stalled");

    // Back-pressure only ever comes from a stalled pixel
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall == (pixel_valid && pixel_stall))
        else $error("item_stall does not follow the pixel side");

    // Pipeline is empty straight after reset
    a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !pixel_valid)
        else $error("pixel valid straight after reset");

    // A written low height reads back in the next cycle
    a_min_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && (paddr[APB_ADDR_BITS-1:2] == REG_HEIGHT_MIN)
         && $past(psel && penable && pwrite && (paddr[APB_ADDR_BITS-1:2] == REG_HEIGHT_MIN)))
        |-> (prdata[HEIGHT_BITS-1:0] == $past(pwdata[HEIGHT_BITS-1:0])))
        else $error("height_min read back wrong");

endmodule

bind height_gradient_color_map hgcm_checker #(
    .HEIGHT_BITS (HEIGHT_BITS)
) u_hgcm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_stall  (item_stall),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_rgb   (pixel_rgb),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
